[rtl/rrss_pkg.sv]
package rrss_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int ID_W    = 8;
  localparam int TIME_W  = 16;
  localparam int CLK_W   = 32;
  localparam int SIGN_W  = 33;
  localparam int ST_W    = 3;
  localparam int MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [ST_W-1:0] ST_LOADED   = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_SLICE    = 3'd2;
  localparam logic [ST_W-1:0] ST_FINISHED = 3'd3;
  localparam logic [ST_W-1:0] ST_ALL_DONE = 3'd4;
  localparam logic [ST_W-1:0] ST_CLEARED  = 3'd5;

  localparam logic [TIME_W-1:0] QUANTUM_RST = 16'd4;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/rrss_ram.sv]
module rrss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/round_robin_slice_scheduler.sv]
// round-robin time-slice scheduler
// input channel (in_valid / in_stall): one beat is a command, in_mode selects
//   load a task, run one scheduling step, or clear the table and clock.
// result channel (out_valid / out_stall): one beat per load, step or clear
//   command; mode 3 is taken and gives no beat.
// configuration: APB-style port, register 0 at address 0 holds the quantum.
// timing: a load or clear beat shows on the output the cycle after it is
//   taken. a step scans the task table one entry per cycle through the
//   single read port of the table RAM, starting after the task last
//   served; a step on an empty table answers like a load.
// one command is worked on at a time; in_stall stays high while a step
//   scans or its result waits for the output register.
// when out_stall is high the result holds in the output register and no new
//   command is taken until it leaves.
// reset clears the task count, scan pointer and clock and sets the quantum
//   to 4; the table RAM itself is not cleared, only entries below the count
//   are ever read.
module round_robin_slice_scheduler
  import rrss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic [ID_W-1:0]          in_task_id,
  input  logic [TIME_W-1:0]        in_arrival_time,
  input  logic [TIME_W-1:0]        in_burst_time,

  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ST_W-1:0]          out_status,
  output logic [ID_W-1:0]          out_served_id,
  output logic [CLK_W-1:0]         out_end_time,
  output logic signed [SIGN_W-1:0] out_wait_time,
  output logic signed [SIGN_W-1:0] out_turnaround,

  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [CLK_W-1:0]  clock_r, clock_nxt;
  logic [TIME_W-1:0] quantum_r;

  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]  issued_r, issued_nxt;
  logic              chk_valid_r, chk_valid_nxt;
  logic              chk_last_r, chk_last_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;

  logic [ST_W-1:0]   res_status_r, res_status_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic [TIME_W-1:0] sav_arr_r, sav_arr_nxt;
  logic [TIME_W-1:0] sav_burst_r, sav_burst_nxt;

  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [ID_W-1:0]   out_id_r;
  logic [CLK_W-1:0]  out_end_r;
  logic [SIGN_W-1:0] out_wait_r;
  logic [SIGN_W-1:0] out_tat_r;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wentry;
  entry_t            ram_rentry;
  logic [ENTRY_W-1:0] ram_rdata;

  logic              in_acc;
  logic              out_free;
  logic              cfg_wr;
  logic              out_load;
  logic [ST_W-1:0]   ld_status;
  logic [ID_W-1:0]   ld_id;
  logic [CLK_W-1:0]  ld_end;
  logic [SIGN_W-1:0] ld_wait;
  logic [SIGN_W-1:0] ld_tat;

  logic [TIME_W-1:0] quantum;
  logic [TIME_W-1:0] slice;
  logic [CNT_W-1:0]  rd_idx_inc;
  logic [CNT_W-1:0]  chk_idx_inc;
  logic [CNT_W-1:0]  issued_inc;
  logic [SIGN_W-1:0] fin_wait;
  logic [SIGN_W-1:0] fin_tat;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata   = (paddr[2] == 1'b0) ? {16'd0, quantum_r} : 32'd0;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  assign quantum     = (quantum_r == '0) ? TIME_W'(1) : quantum_r;
  assign ram_rentry  = entry_t'(ram_rdata);
  assign slice       = (ram_rentry.remaining > quantum) ? quantum : ram_rentry.remaining;
  assign rd_idx_inc  = CNT_W'(rd_idx_r) + CNT_W'(1);
  assign chk_idx_inc = CNT_W'(chk_idx_r) + CNT_W'(1);
  assign issued_inc  = issued_r + CNT_W'(1);

  // finish figures from the already advanced clock
  assign fin_wait = {1'b0, clock_r} - SIGN_W'(sav_arr_r) - SIGN_W'(sav_burst_r);
  assign fin_tat  = {1'b0, clock_r} - SIGN_W'(sav_arr_r);

  rrss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    clock_nxt      = clock_r;
    rd_idx_nxt     = rd_idx_r;
    issued_nxt     = issued_r;
    chk_valid_nxt  = 1'b0;
    chk_last_nxt   = chk_last_r;
    chk_idx_nxt    = chk_idx_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    sav_arr_nxt    = sav_arr_r;
    sav_burst_nxt  = sav_burst_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[IDX_W-1:0];
    ram_wentry     = '{id: in_task_id, arrival: in_arrival_time,
                       burst: in_burst_time, remaining: in_burst_time};
    out_load       = 1'b0;
    ld_status      = ST_LOADED;
    ld_id          = '0;
    ld_end         = '0;
    ld_wait        = '0;
    ld_tat         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            MODE_LOAD: begin
              out_load = 1'b1;
              if (count_r < CNT_W'(MAX_TASKS)) begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                ld_status = ST_LOADED;
              end else begin
                ld_status = ST_FULL;
              end
            end
            MODE_CLEAR: begin
              out_load  = 1'b1;
              ld_status = ST_CLEARED;
              count_nxt = '0;
              ptr_nxt   = '0;
              clock_nxt = '0;
            end
            MODE_STEP: begin
              if (count_r == '0) begin
                out_load  = 1'b1;
                ld_status = ST_ALL_DONE;
                ld_end    = clock_r;
              end else begin
                state_nxt  = S_SCAN;
                rd_idx_nxt = (CNT_W'(ptr_r) < count_r) ? ptr_r : '0;
                issued_nxt = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // one table read issued per cycle, checked when its registered read data returns
        if (issued_r < count_r) begin
          chk_valid_nxt = 1'b1;
          chk_idx_nxt   = rd_idx_r;
          chk_last_nxt  = (issued_inc == count_r);
          issued_nxt    = issued_inc;
          rd_idx_nxt    = (rd_idx_inc == count_r) ? '0 : rd_idx_inc[IDX_W-1:0];
        end
        if (chk_valid_r) begin
          if (ram_rentry.remaining != '0) begin
            chk_valid_nxt = 1'b0;
            state_nxt     = S_DONE;
            ram_we        = 1'b1;
            ram_waddr     = chk_idx_r;
            ram_wentry    = ram_rentry;
            ram_wentry.remaining = ram_rentry.remaining - slice;
            clock_nxt     = clock_r + CLK_W'(slice);
            ptr_nxt       = (chk_idx_inc == count_r) ? '0 : chk_idx_inc[IDX_W-1:0];
            res_id_nxt    = ram_rentry.id;
            sav_arr_nxt   = ram_rentry.arrival;
            sav_burst_nxt = ram_rentry.burst;
            res_status_nxt = (ram_rentry.remaining > quantum) ? ST_SLICE : ST_FINISHED;
          end else if (chk_last_r) begin
            chk_valid_nxt  = 1'b0;
            state_nxt      = S_DONE;
            res_status_nxt = ST_ALL_DONE;
            res_id_nxt     = '0;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          ld_status = res_status_r;
          ld_id     = res_id_r;
          ld_end    = clock_r;
          if (res_status_r == ST_FINISHED) begin
            ld_wait = fin_wait;
            ld_tat  = fin_tat;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      clock_r     <= '0;
      quantum_r   <= QUANTUM_RST;
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      clock_r     <= clock_nxt;
      chk_valid_r <= chk_valid_nxt;
      if (cfg_wr) begin
        quantum_r <= pwdata[TIME_W-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    issued_r     <= issued_nxt;
    chk_last_r   <= chk_last_nxt;
    chk_idx_r    <= chk_idx_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    sav_arr_r    <= sav_arr_nxt;
    sav_burst_r  <= sav_burst_nxt;
    if (out_load) begin
      out_status_r <= ld_status;
      out_id_r     <= ld_id;
      out_end_r    <= ld_end;
      out_wait_r   <= ld_wait;
      out_tat_r    <= ld_tat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_served_id  = out_id_r;
  assign out_end_time   = out_end_r;
  assign out_wait_time  = out_wait_r;
  assign out_turnaround = out_tat_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TASKS))
    else $error("task count beyond table depth");

  a_step_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode == MODE_STEP && count_r != '0) |=> state_r == S_SCAN)
    else $error("step on a non-empty table did not start a scan");

  a_scan_write: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == S_SCAN) |-> (chk_valid_r && CNT_W'(chk_idx_r) < count_r))
    else $error("table write-back without a checked entry");

  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (state_r == S_IDLE && out_valid_r))
    else $error("step result not delivered to output register");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_status_r))
    else $error("stalled result overwritten");

endmodule
